[design/rtisd_pkg.sv]
// shared constants, types and codes of the record table
`timescale 1ns / 1ps
`default_nettype none

package rtisd_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 64;
    localparam int REC_W       = 3 * KEY_W;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int IDX_W       = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_PRINT  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_INSERT_ERR = 3'd1,
        ST_SEARCH_ERR = 3'd2,
        ST_DELETE_ERR = 3'd3,
        ST_PRINT_ERR  = 3'd4
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] first_key;
        logic [KEY_W-1:0] last_key;
        logic [KEY_W-1:0] phone_key;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             idle;
    } t_bk_mon;

endpackage

`default_nettype wire

[design/rtisd_in_if.sv]
// command channel: valid, ready and one command
`timescale 1ns / 1ps
`default_nettype none

interface rtisd_in_if;
    logic                              valid;
    logic                              ready;
    logic [rtisd_pkg::OP_W-1:0]        operation;
    logic [rtisd_pkg::KEY_W-1:0]       first_key;
    logic [rtisd_pkg::KEY_W-1:0]       last_key;
    logic [rtisd_pkg::KEY_W-1:0]       phone_key;

    modport source (
        output valid, operation, first_key, last_key, phone_key,
        input  ready
    );
    modport sink (
        input  valid, operation, first_key, last_key, phone_key,
        output ready
    );
endinterface

`default_nettype wire

[design/rtisd_out_if.sv]
// result channel: valid, ready and one result
`timescale 1ns / 1ps
`default_nettype none

interface rtisd_out_if;
    logic                              valid;
    logic                              ready;
    logic [rtisd_pkg::STATUS_W-1:0]    status;
    logic [rtisd_pkg::IDX_W-1:0]       entry_index;
    logic [rtisd_pkg::KEY_W-1:0]       out_first;
    logic [rtisd_pkg::KEY_W-1:0]       out_last;
    logic [rtisd_pkg::KEY_W-1:0]       out_phone;
    logic                              last_of_run;

    modport source (
        output valid, status, entry_index, out_first, out_last, out_phone, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, out_first, out_last, out_phone, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

[design/rtisd_ram.sv]
// generic single write port, single registered read port ram
`timescale 1ns / 1ps
`default_nettype none

module rtisd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  i_wr_addr,
    input  wire logic [WIDTH-1:0]                          i_wr_data,
    input  wire logic                                      i_rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  i_rd_addr,
    output logic      [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/rtisd_front.sv]
// front end: takes commands, decodes the operation, two-entry command queue
`timescale 1ns / 1ps
`default_nettype none

module rtisd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rtisd_in_if.sink           i_req,
    input  wire logic          i_pop,
    output rtisd_pkg::t_cmd_q  o_cmd
);

    localparam int QD = 2;
    localparam int PW = $clog2(QD);
    localparam int FW = $clog2(QD + 1);

    rtisd_pkg::t_cmd  r_q [QD];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;
    rtisd_pkg::t_cmd  in_cmd;
    logic             push;
    logic             pop;

    assign in_cmd.op        = rtisd_pkg::t_op'(i_req.operation);
    assign in_cmd.first_key = i_req.first_key;
    assign in_cmd.last_key  = i_req.last_key;
    assign in_cmd.phone_key = i_req.phone_key;

    assign i_req.ready = (r_fill != FW'(QD));
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_fill != '0);

    assign o_cmd.valid = (r_fill != '0);
    assign o_cmd.cmd   = r_q[r_rd];

    always_comb begin
        n_fill = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + FW'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wr <= (r_wr == PW'(QD - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(QD - 1)) ? '0 : r_rd + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

[design/rtisd_back.sv]
// back end: table memory, scan, shift and print sequencer, result register
`timescale 1ns / 1ps
`default_nettype none

module rtisd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  rtisd_pkg::t_cmd_q   i_cmd,
    output logic                o_pop,
    rtisd_out_if.source         o_rsp,
    output rtisd_pkg::t_bk_mon  o_mon
);

    localparam int AW = rtisd_pkg::ADDR_W;
    localparam int CW = rtisd_pkg::CNT_W;
    localparam int KW = rtisd_pkg::KEY_W;
    localparam int RW = rtisd_pkg::REC_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_PRINT = 5'b01000,
        S_REPLY = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    rtisd_pkg::t_cmd     r_cmd, n_cmd;
    logic [AW-1:0]       r_ptr, n_ptr;
    rtisd_pkg::t_status  r_rep_status, n_rep_status;
    logic [AW-1:0]       r_rep_idx, n_rep_idx;

    logic                r_out_valid;
    rtisd_pkg::t_status  r_out_status;
    logic [rtisd_pkg::IDX_W-1:0] r_out_idx;
    logic [RW-1:0]       r_out_rec;
    logic                r_out_last;

    logic                ld_out;
    rtisd_pkg::t_status  ld_status;
    logic [AW-1:0]       ld_idx;
    logic [RW-1:0]       ld_rec;
    logic                ld_last;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [RW-1:0]       wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [RW-1:0]       rd_data;

    logic                out_free;
    logic                hit;
    logic                more;
    logic                full;

    rtisd_ram #(
        .WIDTH (RW),
        .DEPTH (rtisd_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free = !r_out_valid || o_rsp.ready;
    assign hit      = (rd_data == {r_cmd.first_key, r_cmd.last_key, r_cmd.phone_key});
    assign more     = ((CW'(r_ptr) + CW'(1)) < r_count);
    assign full     = (r_count == CW'(rtisd_pkg::TABLE_DEPTH));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cmd        = r_cmd;
        n_ptr        = r_ptr;
        n_rep_status = r_rep_status;
        n_rep_idx    = r_rep_idx;
        o_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_ptr;
        wr_data      = rd_data;
        rd_en        = 1'b0;
        rd_addr      = r_ptr;
        ld_out       = 1'b0;
        ld_status    = rtisd_pkg::ST_OK;
        ld_idx       = r_ptr;
        ld_rec       = rd_data;
        ld_last      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_cmd.cmd;
                    n_rep_idx = '0;
                    unique case (i_cmd.cmd.op)
                        rtisd_pkg::OP_INSERT: begin
                            if (full) begin
                                n_rep_status = rtisd_pkg::ST_INSERT_ERR;
                                n_state      = S_REPLY;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(r_count);
                                wr_data = {i_cmd.cmd.first_key, i_cmd.cmd.last_key,
                                           i_cmd.cmd.phone_key};
                                n_count = r_count + CW'(1);
                            end
                        end
                        rtisd_pkg::OP_SEARCH, rtisd_pkg::OP_DELETE: begin
                            if (r_count == '0) begin
                                n_rep_status = (i_cmd.cmd.op == rtisd_pkg::OP_SEARCH) ?
                                               rtisd_pkg::ST_SEARCH_ERR :
                                               rtisd_pkg::ST_DELETE_ERR;
                                n_state      = S_REPLY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(r_count - CW'(1));
                                n_ptr   = AW'(r_count - CW'(1));
                                n_state = S_SCAN;
                            end
                        end
                        rtisd_pkg::OP_PRINT: begin
                            if (r_count == '0) begin
                                n_rep_status = rtisd_pkg::ST_PRINT_ERR;
                                n_state      = S_REPLY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_ptr   = '0;
                                n_state = S_PRINT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                // walk down from the newest entry, first hit is the highest
                if (hit) begin
                    if (r_cmd.op == rtisd_pkg::OP_SEARCH) begin
                        n_rep_status = rtisd_pkg::ST_OK;
                        n_rep_idx    = r_ptr;
                        n_state      = S_REPLY;
                    end else if (more) begin
                        rd_en   = 1'b1;
                        rd_addr = r_ptr + AW'(1);
                        n_ptr   = r_ptr + AW'(1);
                        n_state = S_SHIFT;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = S_IDLE;
                    end
                end else if (r_ptr == '0) begin
                    n_rep_status = (r_cmd.op == rtisd_pkg::OP_SEARCH) ?
                                   rtisd_pkg::ST_SEARCH_ERR : rtisd_pkg::ST_DELETE_ERR;
                    n_rep_idx    = '0;
                    n_state      = S_REPLY;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr - AW'(1);
                    n_ptr   = r_ptr - AW'(1);
                end
            end
            S_SHIFT: begin
                // entry at r_ptr is on the read port, move it one place down
                wr_en   = 1'b1;
                wr_addr = r_ptr - AW'(1);
                wr_data = rd_data;
                if (more) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr + AW'(1);
                    n_ptr   = r_ptr + AW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end
            end
            S_PRINT: begin
                if (out_free) begin
                    ld_out    = 1'b1;
                    ld_status = rtisd_pkg::ST_OK;
                    ld_idx    = r_ptr;
                    ld_rec    = rd_data;
                    ld_last   = !more;
                    if (more) begin
                        rd_en   = 1'b1;
                        rd_addr = r_ptr + AW'(1);
                        n_ptr   = r_ptr + AW'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    ld_out    = 1'b1;
                    ld_status = r_rep_status;
                    ld_idx    = r_rep_idx;
                    ld_rec    = '0;
                    ld_last   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_ptr        <= n_ptr;
        r_rep_status <= n_rep_status;
        r_rep_idx    <= n_rep_idx;
        if (ld_out) begin
            r_out_status <= ld_status;
            r_out_idx    <= rtisd_pkg::IDX_W'(ld_idx);
            r_out_rec    <= ld_rec;
            r_out_last   <= ld_last;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_index = r_out_idx;
    assign o_rsp.out_first   = r_out_rec[RW-1 -: KW];
    assign o_rsp.out_last    = r_out_rec[RW-KW-1 -: KW];
    assign o_rsp.out_phone   = r_out_rec[KW-1:0];
    assign o_rsp.last_of_run = r_out_last;

    assign o_mon.count = r_count;
    assign o_mon.idle  = (r_state == S_IDLE);

endmodule

`default_nettype wire

[design/record_table_insert_search_delete.sv]
// top level of the record table with insert, search, delete and print
// usage:
// commands enter on i_req (operation and three 64-bit keys), results leave on o_rsp.
// a transfer happens on a clock edge with valid and ready both high.
// a two-entry command queue sits in front of the sequencer, so i_req keeps
// taking commands while the sequencer works or o_rsp is stalled, until the queue is full.
// work per command in the sequencer:
//   insert: one table write; insert error: an error result
//   search: one entry compared per cycle from the newest down
//   delete: a compare pass from the newest down, then the entries above the hit shift down, one memory
//   read and write per cycle on the single table ram; a miss ends in an error result
//   print: one result per cycle when o_rsp is ready
// a command passes through the queue and the sequencer before its result reaches the output register.
// results are held in an output register; when o_rsp.ready is low the
// sequencer waits and nothing is lost.
// reset empties the table and the queue and drops any pending result;
// no clearing pass is needed, the table is available the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module record_table_insert_search_delete (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rtisd_in_if.sink      i_req,
    rtisd_out_if.source   o_rsp
);

    rtisd_pkg::t_cmd_q   cmd;
    logic                pop;
    rtisd_pkg::t_bk_mon  mon;

    rtisd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_cmd   (cmd)
    );

    rtisd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_pop   (pop),
        .o_rsp   (o_rsp),
        .o_mon   (mon)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mon.count <= rtisd_pkg::CNT_W'(rtisd_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mon.count != $past(mon.count)) |->
        ((mon.count == $past(mon.count) + rtisd_pkg::CNT_W'(1)) ||
         (mon.count + rtisd_pkg::CNT_W'(1) == $past(mon.count))))
        else $error("entry count moved by more than one");

    a_shrink_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mon.count + rtisd_pkg::CNT_W'(1) == $past(mon.count)) |-> !$past(mon.idle))
        else $error("entry count dropped outside a delete");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != rtisd_pkg::ST_OK)) |->
        (o_rsp.last_of_run && (o_rsp.entry_index == '0) && (o_rsp.out_first == '0)))
        else $error("error result not a lone zero result");

    a_run_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.last_of_run) |-> (o_rsp.status == rtisd_pkg::ST_OK))
        else $error("non-final result carries an error");

endmodule

`default_nettype wire

[tb/sv/tb_record_table_insert_search_delete.sv]
// testbench: directed and random record table commands checked against a local table predictor
`timescale 1ns / 1ps
`default_nettype none

module tb_record_table_insert_search_delete;
    import rtisd_pkg::*;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_CMDS   = 155;
    localparam int POOL_SIZE     = 6;
    localparam int LONG_HOLD     = 90;
    localparam int SETTLE_CYCLES = 64;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] entry_index;
        logic [KEY_W-1:0] first;
        logic [KEY_W-1:0] last;
        logic [KEY_W-1:0] phone;
        logic             last_of_run;
    } t_table_result;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] first;
        logic [KEY_W-1:0] last;
        logic [KEY_W-1:0] phone;
        logic             has_answer;
        t_status          exp_status;
        logic [IDX_W-1:0] exp_index;
    } t_cmd_row;

    typedef enum {RSP_FREE, RSP_MOSTLY, RSP_SPARSE, RSP_TOGGLE} t_rsp_mode;

    logic i_clk;
    logic i_rst_n;

    rtisd_in_if  cmd_chan ();
    rtisd_out_if rsp_chan ();

    record_table_insert_search_delete u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cmd_chan),
        .o_rsp   (rsp_chan)
    );

    // table predictor state
    logic [KEY_W-1:0] tbl_first [TABLE_DEPTH];
    logic [KEY_W-1:0] tbl_last  [TABLE_DEPTH];
    logic [KEY_W-1:0] tbl_phone [TABLE_DEPTH];
    int               tbl_count = 0;
    t_table_result    expected_results [$];

    // record pool for random commands
    logic [KEY_W-1:0] pool_first [POOL_SIZE];
    logic [KEY_W-1:0] pool_last  [POOL_SIZE];
    logic [KEY_W-1:0] pool_phone [POOL_SIZE];

    int               error_count = 0;
    int               burst_left  = 0;
    bit               rsp_hold_req = 1'b0;
    bit               draining     = 1'b0;
    logic             drv_has_answer;
    t_status          drv_exp_status;
    logic [IDX_W-1:0] drv_exp_index;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_error(string msg);
        $display("%0t mismatch: %0s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        if (got !== want) begin
            report_error($sformatf("%0s got %h, expected %h", name, got, want));
        end
    endtask

    function automatic t_table_result make_result(t_status st, int idx, logic [KEY_W-1:0] f,
                                                  logic [KEY_W-1:0] l, logic [KEY_W-1:0] p,
                                                  logic last_flag);
        t_table_result r;
        r.status      = st;
        r.entry_index = idx[IDX_W-1:0];
        r.first       = f;
        r.last        = l;
        r.phone       = p;
        r.last_of_run = last_flag;
        return r;
    endfunction

    function automatic int highest_match(logic [KEY_W-1:0] f, logic [KEY_W-1:0] l,
                                         logic [KEY_W-1:0] p);
        int hit;
        hit = -1;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_first[i] == f && tbl_last[i] == l && tbl_phone[i] == p) hit = i;
        end
        return hit;
    endfunction

    function automatic void apply_table_cmd(t_op op, logic [KEY_W-1:0] f, logic [KEY_W-1:0] l,
                                            logic [KEY_W-1:0] p);
        int hit;
        case (op)
            OP_INSERT: begin
                if (tbl_count < TABLE_DEPTH) begin
                    tbl_first[tbl_count] = f;
                    tbl_last[tbl_count]  = l;
                    tbl_phone[tbl_count] = p;
                    tbl_count++;
                end else begin
                    expected_results.push_back(make_result(ST_INSERT_ERR, 0, '0, '0, '0, 1'b1));
                end
            end
            OP_SEARCH: begin
                hit = highest_match(f, l, p);
                if (hit >= 0) begin
                    expected_results.push_back(make_result(ST_OK, hit, '0, '0, '0, 1'b1));
                end else begin
                    expected_results.push_back(make_result(ST_SEARCH_ERR, 0, '0, '0, '0, 1'b1));
                end
            end
            OP_DELETE: begin
                hit = highest_match(f, l, p);
                if (hit < 0) begin
                    expected_results.push_back(make_result(ST_DELETE_ERR, 0, '0, '0, '0, 1'b1));
                end else begin
                    for (int i = hit; i < tbl_count - 1; i++) begin
                        tbl_first[i] = tbl_first[i + 1];
                        tbl_last[i]  = tbl_last[i + 1];
                        tbl_phone[i] = tbl_phone[i + 1];
                    end
                    tbl_count--;
                end
            end
            default: begin
                if (tbl_count == 0) begin
                    expected_results.push_back(make_result(ST_PRINT_ERR, 0, '0, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < tbl_count; i++) begin
                        expected_results.push_back(make_result(ST_OK, i, tbl_first[i],
                                                               tbl_last[i], tbl_phone[i],
                                                               i == tbl_count - 1));
                    end
                end
            end
        endcase
    endfunction

    // directed stimulus table
    function automatic t_cmd_row directed_row(int n);
        t_cmd_row row;
        row = '0;
        case (n)
            0: begin
                row.op         = OP_PRINT;
                row.has_answer = 1'b1;
                row.exp_status = ST_PRINT_ERR;
            end
            1: begin
                row.op         = OP_SEARCH;
                row.has_answer = 1'b1;
                row.exp_status = ST_SEARCH_ERR;
            end
            2: begin
                row.op         = OP_DELETE;
                row.first      = '1;
                row.last       = '1;
                row.phone      = '1;
                row.has_answer = 1'b1;
                row.exp_status = ST_DELETE_ERR;
            end
            3: row.op = OP_INSERT;
            4, 5, 7: begin
                row.op    = (n == 7) ? OP_DELETE : OP_INSERT;
                row.first = '1;
                row.last  = '1;
                row.phone = '1;
            end
            6, 8: begin
                // duplicates resolve to the highest position
                row.op         = OP_SEARCH;
                row.first      = '1;
                row.last       = '1;
                row.phone      = '1;
                row.has_answer = 1'b1;
                row.exp_status = ST_OK;
                row.exp_index  = (n == 6) ? 4'd2 : 4'd1;
            end
            23: begin
                row.op         = OP_INSERT;
                row.first      = '1;
                row.has_answer = 1'b1;
                row.exp_status = ST_INSERT_ERR;
            end
            24: row.op = OP_PRINT;
            default: begin
                row.op    = OP_INSERT;
                row.first = {"ann", 8'(n)};
                row.last  = "lee";
                row.phone = {"555", 8'(n)};
            end
        endcase
        return row;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'($urandom_range(1, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void refresh_pool_slot(int s);
        pool_first[s] = random_key();
        pool_last[s]  = random_key();
        pool_phone[s] = random_key();
    endfunction

    function automatic t_cmd_row random_cmd();
        t_cmd_row row;
        int       pick;
        int       roll;
        int       slot;
        int       ins_lim;
        int       srch_lim;
        row  = '0;
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        slot = $urandom_range(0, POOL_SIZE - 1);
        if (tbl_count >= TABLE_DEPTH - 2) begin
            ins_lim  = 25;
            srch_lim = 50;
        end else if (tbl_count <= 2) begin
            ins_lim  = 55;
            srch_lim = 70;
        end else begin
            ins_lim  = 35;
            srch_lim = 60;
        end
        if (pick < ins_lim) row.op = OP_INSERT;
        else if (pick < srch_lim) row.op = OP_SEARCH;
        else if (pick < 85) row.op = OP_DELETE;
        else row.op = OP_PRINT;

        if (row.op == OP_INSERT && roll < 15) refresh_pool_slot(slot);
        row.first = pool_first[slot];
        row.last  = pool_last[slot];
        row.phone = pool_phone[slot];

        if (row.op == OP_PRINT || ((row.op != OP_INSERT) && roll >= 15 && roll < 25)) begin
            row.first = random_key();
            row.last  = random_key();
            row.phone = random_key();
        end else if (row.op != OP_INSERT && roll < 15) begin
            // near miss: one bit off in one key
            case ($urandom_range(0, 2))
                0:       row.first ^= 64'd1 << $urandom_range(0, 63);
                1:       row.last  ^= 64'd1 << $urandom_range(0, 63);
                default: row.phone ^= 64'd1 << $urandom_range(0, 63);
            endcase
        end
        return row;
    endfunction

    task automatic sender_pause();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_chan.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_cmd(t_cmd_row row);
        drv_has_answer = row.has_answer;
        drv_exp_status = row.exp_status;
        drv_exp_index  = row.exp_index;
        cmd_chan.valid     <= 1'b1;
        cmd_chan.operation <= row.op;
        cmd_chan.first_key <= row.first;
        cmd_chan.last_key  <= row.last;
        cmd_chan.phone_key <= row.phone;
        do @(posedge i_clk); while (!cmd_chan.ready);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : transfer_monitor
        t_table_result want;
        int            depth_before;
        if (i_rst_n) begin
            if (rsp_chan.valid && rsp_chan.ready) begin
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result with nothing expected, status %0d index %0d",
                                           rsp_chan.status, rsp_chan.entry_index));
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", rsp_chan.status, want.status);
                    check_field("entry_index", rsp_chan.entry_index, want.entry_index);
                    check_field("out_first", rsp_chan.out_first, want.first);
                    check_field("out_last", rsp_chan.out_last, want.last);
                    check_field("out_phone", rsp_chan.out_phone, want.phone);
                    check_field("last_of_run", rsp_chan.last_of_run, want.last_of_run);
                end
            end
            if (cmd_chan.valid && cmd_chan.ready) begin
                depth_before = expected_results.size();
                apply_table_cmd(t_op'(cmd_chan.operation), cmd_chan.first_key,
                                cmd_chan.last_key, cmd_chan.phone_key);
                if (drv_has_answer) begin
                    while (expected_results.size() > depth_before) begin
                        expected_results.delete(expected_results.size() - 1);
                    end
                    expected_results.push_back(make_result(drv_exp_status, drv_exp_index,
                                                           '0, '0, '0, 1'b1));
                end
            end
        end
    end

    initial begin : rsp_pacing
        t_rsp_mode mode;
        int        phase_left;
        int        held;
        mode       = RSP_FREE;
        phase_left = 0;
        held       = 0;
        rsp_chan.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (draining) begin
                rsp_chan.ready <= 1'b1;
            end else if (rsp_hold_req) begin
                rsp_chan.ready <= 1'b0;
                held++;
                if (held == LONG_HOLD) begin
                    held         = 0;
                    rsp_hold_req = 1'b0;
                end
            end else begin
                if (phase_left == 0) begin
                    mode       = t_rsp_mode'($urandom_range(0, 3));
                    phase_left = $urandom_range(4, 40);
                end
                phase_left--;
                case (mode)
                    RSP_FREE:   rsp_chan.ready <= 1'b1;
                    RSP_MOSTLY: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
                    RSP_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
                    default:    rsp_chan.ready <= phase_left[0];
                endcase
            end
        end
    end

    initial begin : stimulus
        i_rst_n            = 1'b0;
        cmd_chan.valid     = 1'b0;
        cmd_chan.operation = OP_INSERT;
        cmd_chan.first_key = '0;
        cmd_chan.last_key  = '0;
        cmd_chan.phone_key = '0;
        drv_has_answer     = 1'b0;
        drv_exp_status     = ST_OK;
        drv_exp_index      = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            sender_pause();
            send_cmd(directed_row(n));
        end

        for (int s = 0; s < POOL_SIZE; s++) refresh_pool_slot(s);
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            // long result stall while commands keep coming
            if (n == 40 || n == 140) rsp_hold_req = 1'b1;
            if (n == 100) begin
                cmd_chan.valid <= 1'b0;
                do @(negedge i_clk); while (expected_results.size() != 0);
            end
            sender_pause();
            send_cmd(random_cmd());
        end

        draining = 1'b1;
        cmd_chan.valid <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t timeout, %0d results still expected", $time, expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
